/* rtl/ffba_pkg.sv */
package ffba_pkg;

  localparam int AddrW = 32;
  localparam int SizeW = 18;
  localparam int StatW = 3;

  localparam logic [AddrW-1:0] BaseReset  = 32'h0200_0100;
  localparam logic [AddrW-1:0] LimitReset = 32'h0203_0000;

  localparam logic [StatW-1:0] StOk        = 3'd0;
  localparam logic [StatW-1:0] StUsedFull  = 3'd1;
  localparam logic [StatW-1:0] StSpareFull = 3'd2;
  localparam logic [StatW-1:0] StNoMemory  = 3'd3;
  localparam logic [StatW-1:0] StUnknown   = 3'd4;

  localparam logic RegBase  = 1'b0;
  localparam logic RegLimit = 1'b1;

  localparam logic FuncAlloc = 1'b0;
  localparam logic FuncFree  = 1'b1;

  typedef enum logic [2:0] {
    StIdle,
    StRead,
    StCheck,
    StShiftRd,
    StShiftWr,
    StDone
  } state_e;

endpackage

/* rtl/first_fit_block_allocator.sv */
// First-fit block allocator. A request on start (accepted when busy is low)
// allocates (func_i = 0) or frees (func_i = 1); exactly one result appears on
// block_addr_o/status_o for a single cycle with done_o high, and the receiver
// cannot stall it. The block walks the table one entry at a time through a
// single read port (read, then compare), and closes a gap by moving entries
// one at a time (read, then write). Configuration writes are taken while no
// request is in flight.
module first_fit_block_allocator
  import ffba_pkg::*;
#(
  parameter int USED_ENTRIES  = 256,
  parameter int SPARE_ENTRIES = 256
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  logic             func_i,
  input  logic [SizeW-1:0] req_size_i,
  input  logic [AddrW-1:0] req_addr_i,
  output logic             done_o,
  output logic [AddrW-1:0] block_addr_o,
  output logic [StatW-1:0] status_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic             cfg_index_i,
  input  logic [AddrW-1:0] cfg_data_i
);

  localparam int UIW = $clog2(USED_ENTRIES);
  localparam int SIW = $clog2(SPARE_ENTRIES);
  localparam int UCW = $clog2(USED_ENTRIES + 1);
  localparam int SCW = $clog2(SPARE_ENTRIES + 1);
  localparam int IW  = (UCW > SCW) ? UCW : SCW;

  logic [AddrW-1:0] used_addr_mem  [USED_ENTRIES];
  logic [SizeW-1:0] used_size_mem  [USED_ENTRIES];
  logic [AddrW-1:0] spare_addr_mem [SPARE_ENTRIES];
  logic [SizeW-1:0] spare_size_mem [SPARE_ENTRIES];

  state_e state_q, state_d;
  logic [AddrW-1:0] limit_q, bump_q, bump_d;
  logic [UCW-1:0] used_cnt_q, used_cnt_d;
  logic [SCW-1:0] spare_cnt_q, spare_cnt_d;
  logic [IW-1:0] idx_q, idx_d;
  logic func_q;
  logic [SizeW:0] size_q;
  logic [AddrW-1:0] addr_q;
  logic [AddrW-1:0] rd_addr_q;
  logic [SizeW-1:0] rd_size_q;
  logic [AddrW-1:0] res_addr_q, res_addr_d;
  logic [StatW-1:0] res_stat_q, res_stat_d;
  logic done_q, done_d;

  logic            uw_en, sw_en;
  logic [UIW-1:0]  uw_idx;
  logic [SIW-1:0]  sw_idx;
  logic [AddrW-1:0] w_addr;
  logic [SizeW-1:0] w_size;
  logic [IW-1:0]    rd_idx;

  logic [SizeW:0] rsize;
  assign rsize = {1'b0, req_size_i} + (SizeW+1)'(3);

  assign busy         = (state_q != StIdle);
  assign cfg_ready_o  = (state_q == StIdle);
  assign done_o       = done_q;
  assign block_addr_o = res_addr_q;
  assign status_o     = res_stat_q;

  logic [AddrW:0] bump_sum;
  assign bump_sum = {1'b0, bump_q} + {{(AddrW-SizeW){1'b0}}, size_q};

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    bump_d      = bump_q;
    used_cnt_d  = used_cnt_q;
    spare_cnt_d = spare_cnt_q;
    res_addr_d  = res_addr_q;
    res_stat_d  = res_stat_q;
    done_d      = 1'b0;
    uw_en  = 1'b0;
    sw_en  = 1'b0;
    uw_idx = idx_q[UIW-1:0];
    sw_idx = idx_q[SIW-1:0];
    w_addr = rd_addr_q;
    w_size = rd_size_q;
    rd_idx = idx_q;
    case (state_q)
      StIdle: begin
        idx_d = '0;
        if (cfg_valid_i && cfg_index_i == RegBase) bump_d = cfg_data_i;
        if (start) state_d = StRead;
      end
      StRead: begin
        if (func_q == FuncAlloc && size_q[SizeW]) begin
          res_addr_d = '0; res_stat_d = StNoMemory; state_d = StDone;
        end else if (func_q == FuncAlloc && IW'(spare_cnt_q) == idx_q) begin
          if (bump_sum < {1'b0, limit_q}) begin
            if (used_cnt_q == UCW'(USED_ENTRIES)) begin
              res_addr_d = '0; res_stat_d = StUsedFull;
            end else begin
              uw_en = 1'b1; uw_idx = used_cnt_q[UIW-1:0];
              w_addr = bump_q; w_size = size_q[SizeW-1:0];
              used_cnt_d = used_cnt_q + 1'b1;
              bump_d = bump_sum[AddrW-1:0];
              res_addr_d = bump_q; res_stat_d = StOk;
            end
          end else begin
            res_addr_d = '0; res_stat_d = StNoMemory;
          end
          state_d = StDone;
        end else if (func_q == FuncFree && IW'(used_cnt_q) == idx_q) begin
          res_addr_d = '0; res_stat_d = StUnknown; state_d = StDone;
        end else begin
          state_d = StCheck;
        end
      end
      StCheck: begin
        state_d = StRead;
        idx_d = idx_q + 1'b1;
        if (func_q == FuncAlloc) begin
          if (rd_size_q >= size_q[SizeW-1:0]) begin
            state_d = StDone;
            idx_d = idx_q;
            if (used_cnt_q == UCW'(USED_ENTRIES)) begin
              res_addr_d = '0; res_stat_d = StUsedFull;
            end else begin
              uw_en = 1'b1; uw_idx = used_cnt_q[UIW-1:0];
              used_cnt_d = used_cnt_q + 1'b1;
              res_addr_d = rd_addr_q; res_stat_d = StOk;
              if (rd_size_q == size_q[SizeW-1:0]) begin
                spare_cnt_d = spare_cnt_q - 1'b1;
                state_d = StShiftRd;
                idx_d = idx_q + 1'b1;
              end else begin
                w_size = size_q[SizeW-1:0];
                sw_en = 1'b1;
              end
            end
          end
        end else if (rd_addr_q == addr_q) begin
          state_d = StDone;
          res_addr_d = '0;
          if (spare_cnt_q == SCW'(SPARE_ENTRIES)) begin
            res_stat_d = StSpareFull;
          end else begin
            sw_en = 1'b1; sw_idx = spare_cnt_q[SIW-1:0];
            spare_cnt_d = spare_cnt_q + 1'b1;
            used_cnt_d = used_cnt_q - 1'b1;
            res_stat_d = StOk;
            state_d = StShiftRd;
            idx_d = idx_q + 1'b1;
          end
        end
      end
      StShiftRd: begin
        if ((func_q == FuncAlloc && idx_q >= IW'(spare_cnt_q) + 1'b1) ||
            (func_q == FuncFree && idx_q >= IW'(used_cnt_q) + 1'b1)) begin
          state_d = StDone;
        end else begin
          state_d = StShiftWr;
        end
      end
      StShiftWr: begin
        rd_idx = idx_q;
        if (func_q == FuncAlloc) begin
          sw_en = 1'b1; sw_idx = SIW'(idx_q - 1'b1);
        end else begin
          uw_en = 1'b1; uw_idx = UIW'(idx_q - 1'b1);
        end
        idx_d = idx_q + 1'b1;
        state_d = StShiftRd;
      end
      StDone: begin
        done_d = 1'b1;
        state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  // trimmed spare entry data in alloc larger-fit case
  logic [AddrW-1:0] trim_addr;
  logic [SizeW-1:0] trim_size;
  assign trim_addr = rd_addr_q + {{(AddrW-SizeW){1'b0}}, size_q[SizeW-1:0]};
  assign trim_size = rd_size_q - size_q[SizeW-1:0];

  logic split_wr;
  assign split_wr = (state_q == StCheck) && (func_q == FuncAlloc) && sw_en;

  always_ff @(posedge clk_i) begin
    if (uw_en) begin
      used_addr_mem[uw_idx] <= w_addr;
      used_size_mem[uw_idx] <= w_size;
    end
    if (sw_en) begin
      spare_addr_mem[sw_idx] <= split_wr ? trim_addr : w_addr;
      spare_size_mem[sw_idx] <= split_wr ? trim_size : rd_size_q;
    end
    if (state_q == StRead || state_q == StShiftRd) begin
      if (func_q == FuncAlloc) begin
        rd_addr_q <= spare_addr_mem[rd_idx[SIW-1:0]];
        rd_size_q <= spare_size_mem[rd_idx[SIW-1:0]];
      end else begin
        rd_addr_q <= used_addr_mem[rd_idx[UIW-1:0]];
        rd_size_q <= used_size_mem[rd_idx[UIW-1:0]];
      end
    end
    if (state_q == StIdle && start) begin
      func_q <= func_i;
      size_q <= {rsize[SizeW:2], 2'b00};
      addr_q <= req_addr_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      limit_q     <= LimitReset;
      bump_q      <= BaseReset;
      used_cnt_q  <= '0;
      spare_cnt_q <= '0;
      idx_q       <= '0;
      done_q      <= 1'b0;
      res_addr_q  <= '0;
      res_stat_q  <= StOk;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      used_cnt_q  <= used_cnt_d;
      spare_cnt_q <= spare_cnt_d;
      done_q      <= done_d;
      res_addr_q  <= res_addr_d;
      res_stat_q  <= res_stat_d;
      bump_q      <= bump_d;
      if (cfg_valid_i && cfg_ready_o && cfg_index_i == RegLimit) begin
        limit_q <= cfg_data_i;
      end
    end
  end

endmodule
